FILE: design/bole_pkg.sv
// Shared types and constants for the bounded ordered list engine.
// No dependencies.
`timescale 1ns / 1ps

package bole_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DEPTH_MAX = 64;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    // cell command bus is sized for the largest supported list
    localparam int CNT_W = $clog2(DEPTH_MAX + 1);

    typedef logic signed [DATA_W-1:0] t_data;

    // request opcodes; code 7 is unused and changes nothing
    localparam logic [OP_W-1:0] OP_SHOW      = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_FIRST = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_LAST  = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_AT    = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd5;
    localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd6;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_BADPOS = 2'd2,
        STAT_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CK_HOLD   = 2'd0,
        CK_INSERT = 2'd1,
        CK_DELETE = 2'd2,
        CK_ROTATE = 2'd3
    } t_cell_kind;

    // broadcast to every cell: idx is the zero-based target, cnt the
    // occupancy before the operation
    typedef struct packed {
        t_cell_kind       kind;
        logic [CNT_W-1:0] idx;
        logic [CNT_W-1:0] cnt;
    } t_cell_cmd;

endpackage

FILE: design/bole_cell.sv
// One storage cell of the list chain: holds one element and takes its
// next value from itself, a neighbor, the new value or the wrap value.
// Depends on bole_pkg.
`timescale 1ns / 1ps

module bole_cell
    import bole_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic      i_clk,
    input  t_cell_cmd i_cmd,
    input  t_data     i_new,
    input  t_data     i_wrap,
    input  t_data     i_left,
    input  t_data     i_right,
    output t_data     o_data
);

    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(INDEX + 1);

    t_data r_data;
    t_data n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.kind)
            CK_INSERT: begin
                if (i_cmd.idx == IDX_C) begin
                    n_data = i_new;
                end else if (i_cmd.idx < IDX_C && IDX_C <= i_cmd.cnt) begin
                    n_data = i_left;
                end
            end
            CK_DELETE: begin
                if (i_cmd.idx <= IDX_C && IDX_P1 < i_cmd.cnt) begin
                    n_data = i_right;
                end
            end
            // front element goes to the tail slot so show leaves the list intact
            CK_ROTATE: begin
                if (IDX_P1 < i_cmd.cnt) begin
                    n_data = i_right;
                end else if (IDX_P1 == i_cmd.cnt) begin
                    n_data = i_wrap;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: design/bounded_ordered_list_engine.sv
// Ordered list of up to DEPTH signed 32-bit values, kept in a chain of cells.
// Depends on bole_pkg and bole_cell.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. Every request except
// show on a non-empty list gives a single result on the next cycle with o_valid
// high; an insert or delete that is carried out shifts the cells in parallel.
// Show on a list of N elements holds busy while the chain rotates through cell 0
// one element per cycle, so N results appear back to back, front element first,
// and the list is back in place when o_last is seen. Results are strobed for one
// cycle and must be captured then; there is no stall.
module bounded_ordered_list_engine
    import bole_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      i_op,
    input  logic signed [31:0]   i_value,
    input  logic [POS_W-1:0]     i_position,
    output logic                 o_valid,
    output logic signed [31:0]   o_element,
    output logic [SLOT_W-1:0]    o_slot,
    output logic [STATUS_W-1:0]  o_status,
    output logic [LEN_W-1:0]     o_length,
    output logic                 o_last
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = $clog2(DEPTH);
    localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SHOW = 2'b10
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_idx, n_idx;
    logic            r_valid, n_valid;
    t_data           r_element, n_element;
    logic [SLOT_W-1:0] r_slot, n_slot;
    t_status         r_status, n_status;
    logic [LEN_W-1:0] r_length;
    logic            r_last, n_last;

    t_cell_cmd       cmd;
    t_data           w_cell [DEPTH];
    logic [CW-1:0]   tgt;
    logic [CMP_W-1:0] pos_x, cnt_x;

    assign pos_x = CMP_W'(i_position);
    assign cnt_x = CMP_W'(r_count);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_valid   = 1'b0;
        n_element = '0;
        n_slot    = '0;
        n_status  = STAT_OK;
        n_last    = 1'b1;
        tgt       = '0;
        cmd.kind  = CK_HOLD;
        cmd.idx   = '0;
        cmd.cnt   = CNT_W'(r_count);

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_valid = 1'b1;
                    unique case (i_op) inside
                        OP_SHOW: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_valid = 1'b0;
                                n_idx   = '0;
                                n_state = ST_SHOW;
                            end
                        end
                        OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
                            if (r_count == FULL_CNT) begin
                                n_status = STAT_FULL;
                            end else if (i_op == OP_INS_AT &&
                                         (pos_x == '0 || pos_x > cnt_x + CMP_W'(1))) begin
                                n_status = STAT_BADPOS;
                            end else begin
                                if (i_op == OP_INS_FIRST) begin
                                    tgt = '0;
                                end else if (i_op == OP_INS_LAST) begin
                                    tgt = r_count;
                                end else begin
                                    tgt = CW'(pos_x - CMP_W'(1));
                                end
                                cmd.kind = CK_INSERT;
                                cmd.idx  = CNT_W'(tgt);
                                n_count  = r_count + CW'(1);
                            end
                        end
                        OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else if (i_op == OP_DEL_AT &&
                                         (pos_x == '0 || pos_x > cnt_x)) begin
                                n_status = STAT_BADPOS;
                            end else begin
                                if (i_op == OP_DEL_FIRST) begin
                                    tgt = '0;
                                end else if (i_op == OP_DEL_LAST) begin
                                    tgt = r_count - CW'(1);
                                end else begin
                                    tgt = CW'(pos_x - CMP_W'(1));
                                end
                                cmd.kind = CK_DELETE;
                                cmd.idx  = CNT_W'(tgt);
                                n_count  = r_count - CW'(1);
                            end
                        end
                        default: begin
                            n_status = STAT_OK;
                        end
                    endcase
                end
            end
            ST_SHOW: begin
                cmd.kind  = CK_ROTATE;
                n_valid   = 1'b1;
                n_element = w_cell[0];
                n_slot    = SLOT_W'(r_idx);
                n_last    = (CW'(r_idx) + CW'(1)) == r_count;
                if (n_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_element <= n_element;
        r_slot    <= n_slot;
        r_status  <= n_status;
        r_length  <= LEN_W'(n_count);
        r_last    <= n_last;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_data w_left, w_right;
        if (g == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_body
            assign w_left = w_cell[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_right = w_cell[g];
        end else begin : g_mid
            assign w_right = w_cell[g+1];
        end
        bole_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_new   (i_value),
            .i_wrap  (w_cell[0]),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell[g])
        );
    end

    assign busy      = (r_state == ST_SHOW);
    assign o_valid   = r_valid;
    assign o_element = r_element;
    assign o_slot    = r_slot;
    assign o_status  = r_status;
    assign o_length  = r_length;
    assign o_last    = r_last;

endmodule

FILE: test/bounded_ordered_list_engine_tb.sv
// Self-checking testbench for the bounded ordered list engine: directed and random list ops.
// Depends on bole_pkg and the bounded_ordered_list_engine RTL.
`timescale 1ns / 1ps

module bounded_ordered_list_engine_tb;
    import bole_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam int RANDOM_REQS = 300;
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    typedef struct {
        logic [OP_W-1:0]  op;
        t_data            value;
        logic [POS_W-1:0] position;
        int               gap;
    } t_list_req;

    typedef struct {
        t_data             element;
        logic [SLOT_W-1:0] slot;
        t_status           status;
        logic [LEN_W-1:0]  length;
        logic              last;
    } t_list_result;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [OP_W-1:0]      i_op = '0;
    t_data                i_value = '0;
    logic [POS_W-1:0]     i_position = '0;
    logic                 o_valid;
    t_data                o_element;
    logic [SLOT_W-1:0]    o_slot;
    logic [STATUS_W-1:0]  o_status;
    logic [LEN_W-1:0]     o_length;
    logic                 o_last;

    t_list_req    pending_reqs[$];
    t_list_result expected_results[$];

    // predicted list contents
    t_data model_vals[$];
    int    model_len = 0;

    // occupancy as seen while building the stimulus
    int gen_len = 0;

    t_list_req cur_req;
    bit        have_req = 1'b0;
    int        gap_left = 0;
    bit        req_taken = 1'b0;
    int        err_count = 0;

    bounded_ordered_list_engine #(
        .DEPTH(LIST_DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_op       (i_op),
        .i_value    (i_value),
        .i_position (i_position),
        .o_valid    (o_valid),
        .o_element  (o_element),
        .o_slot     (o_slot),
        .o_status   (o_status),
        .o_length   (o_length),
        .o_last     (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic push_result(input t_data element, input int slot, input t_status status,
                               input bit last);
        t_list_result r;
        r.element = element;
        r.slot    = slot[SLOT_W-1:0];
        r.status  = status;
        r.length  = model_len[LEN_W-1:0];
        r.last    = last;
        expected_results.push_back(r);
    endtask

    task automatic apply_list_op(input logic [OP_W-1:0] op, input t_data value,
                                 input logic [POS_W-1:0] position);
        t_status st;
        int      idx;
        int      pos;
        st  = STAT_OK;
        idx = -1;
        pos = int'(position);
        if (op == OP_SHOW) begin
            if (model_len == 0) begin
                push_result('0, 0, STAT_EMPTY, 1'b1);
            end else begin
                for (int i = 0; i < model_len; i++)
                    push_result(model_vals[i], i, STAT_OK, i == model_len - 1);
            end
            return;
        end
        case (op)
            OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
                if (model_len >= LIST_DEPTH) begin
                    st = STAT_FULL;
                end else begin
                    if (op == OP_INS_FIRST) idx = 0;
                    else if (op == OP_INS_LAST) idx = model_len;
                    else if (pos >= 1 && pos <= model_len + 1) idx = pos - 1;
                    else st = STAT_BADPOS;
                    if (idx >= 0) begin
                        model_vals.insert(idx, value);
                        model_len++;
                    end
                end
            end
            OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
                if (model_len == 0) begin
                    st = STAT_EMPTY;
                end else begin
                    if (op == OP_DEL_FIRST) idx = 0;
                    else if (op == OP_DEL_LAST) idx = model_len - 1;
                    else if (pos >= 1 && pos <= model_len) idx = pos - 1;
                    else st = STAT_BADPOS;
                    if (idx >= 0) begin
                        model_vals.delete(idx);
                        model_len--;
                    end
                end
            end
            default: ;
        endcase
        push_result('0, 0, st, 1'b1);
    endtask

    // queues a request and tracks what occupancy it leaves behind
    task automatic queue_request(input logic [OP_W-1:0] op, input t_data value,
                                 input int position, input int gap);
        t_list_req r;
        r.op       = op;
        r.value    = value;
        r.position = position[POS_W-1:0];
        r.gap      = gap;
        pending_reqs.push_back(r);
        case (op)
            OP_INS_FIRST, OP_INS_LAST:
                if (gen_len < LIST_DEPTH) gen_len++;
            OP_INS_AT:
                if (gen_len < LIST_DEPTH && position >= 1 && position <= gen_len + 1)
                    gen_len++;
            OP_DEL_FIRST, OP_DEL_LAST:
                if (gen_len > 0) gen_len--;
            OP_DEL_AT:
                if (gen_len > 0 && position >= 1 && position <= gen_len) gen_len--;
            default: ;
        endcase
    endtask

    function automatic t_data rand_value();
        int pick;
        pick = $urandom_range(0, 19);
        case (pick)
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return t_data'($urandom());
        endcase
    endfunction

    // driver: inputs move on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && !(start && !req_taken)) begin
            if (!have_req && pending_reqs.size() != 0) begin
                cur_req  = pending_reqs.pop_front();
                have_req = 1'b1;
                gap_left = cur_req.gap;
            end
            if (have_req && gap_left == 0) begin
                start      <= 1'b1;
                i_op       <= cur_req.op;
                i_value    <= cur_req.value;
                i_position <= cur_req.position;
                have_req = 1'b0;
            end else begin
                start <= 1'b0;
                if (have_req) gap_left--;
            end
        end
    end

    // monitor: checks results first, then predicts for a request taken this edge
    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            req_taken = 1'b0;
        end else begin
            if (o_valid) begin
                if (expected_results.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"ERROR %0t: unexpected result ",
                                  "elem=%0d slot=%0d st=%0d len=%0d last=%0b"},
                                 $time, o_element, o_slot, o_status, o_length, o_last);
                end else begin
                    want = expected_results.pop_front();
                    if (o_element !== want.element || o_slot !== want.slot ||
                        o_status !== want.status || o_length !== want.length ||
                        o_last !== want.last) begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"ERROR %0t: exp elem=%0d slot=%0d st=%0d len=%0d ",
                                      "last=%0b, got elem=%0d slot=%0d st=%0d len=%0d ",
                                      "last=%0b"},
                                     $time, want.element, want.slot, want.status,
                                     want.length, want.last, o_element, o_slot,
                                     o_status, o_length, o_last);
                    end
                end
            end
            req_taken = start && !busy;
            if (req_taken) apply_list_op(i_op, i_value, i_position);
        end
    end

    initial begin
        int  n_random;
        int  phase_kind;
        int  phase_len;
        int  ins_pct;
        int  roll;
        int  pos;
        int  gap;
        bit  no_idle;
        logic [OP_W-1:0] op;

        // empty list corner cases, value extremes, bad positions
        queue_request(OP_SHOW, '0, 0, $urandom_range(0, 6));
        queue_request(OP_DEL_FIRST, '0, 0, $urandom_range(0, 6));
        queue_request(OP_DEL_LAST, '0, 0, $urandom_range(0, 6));
        queue_request(OP_DEL_AT, '0, 31, $urandom_range(0, 6));
        queue_request(OP_INS_AT, 32'sd5, 0, $urandom_range(0, 6));
        queue_request(OP_INS_AT, 32'sd6, 2, $urandom_range(0, 6));
        queue_request(OP_INS_AT, 32'sh7fff_ffff, 1, 0);
        queue_request(OP_INS_FIRST, 32'sh8000_0000, 31, 0);
        queue_request(OP_INS_LAST, '1, 0, $urandom_range(0, 6));
        queue_request(OP_INS_AT, '0, 2, 0);
        queue_request(OP_INS_AT, 32'sd12345, 5, $urandom_range(0, 6));
        queue_request(OP_INS_AT, 32'sd7, 7, 0);
        queue_request(OP_SHOW, '0, 0, 0);
        queue_request(OP_DEL_AT, '0, 0, $urandom_range(0, 6));
        queue_request(OP_DEL_AT, '0, 6, 0);
        queue_request(OP_DEL_AT, '0, 3, 0);
        queue_request(OP_DEL_FIRST, '0, 0, $urandom_range(0, 6));
        queue_request(OP_DEL_LAST, '0, 0, 0);
        queue_request(OP_UNUSED, '1, 31, 0);
        queue_request(OP_SHOW, '0, 0, 0);
        queue_request(OP_DEL_AT, '0, 2, $urandom_range(0, 6));
        queue_request(OP_DEL_AT, '0, 1, 0);
        queue_request(OP_SHOW, '0, 0, 0);

        // random phases that fill, drain or churn the list
        n_random = 0;
        while (n_random < RANDOM_REQS) begin
            phase_kind = $urandom_range(0, 2);
            phase_len  = $urandom_range(8, 40);
            no_idle    = ($urandom_range(0, 3) == 0);
            ins_pct    = (phase_kind == 0) ? 80 : (phase_kind == 1) ? 15 : 45;
            repeat (phase_len) begin
                roll = $urandom_range(0, 99);
                pos  = $urandom_range(0, 31);
                if (roll < 8) begin
                    op = OP_SHOW;
                end else if (roll < 10) begin
                    op = OP_UNUSED;
                end else if (roll < 10 + ins_pct) begin
                    case ($urandom_range(0, 2))
                        0: op = OP_INS_FIRST;
                        1: op = OP_INS_LAST;
                        default: op = OP_INS_AT;
                    endcase
                    if (op == OP_INS_AT && $urandom_range(0, 99) < 85)
                        pos = $urandom_range(1, gen_len + 1);
                end else begin
                    case ($urandom_range(0, 2))
                        0: op = OP_DEL_FIRST;
                        1: op = OP_DEL_LAST;
                        default: op = OP_DEL_AT;
                    endcase
                    if (op == OP_DEL_AT && gen_len > 0 && $urandom_range(0, 99) < 85)
                        pos = $urandom_range(1, gen_len);
                end
                gap = no_idle ? 0 : $urandom_range(0, 6);
                queue_request(op, rand_value(), pos, gap);
                n_random++;
            end
        end
        queue_request(OP_SHOW, '0, 0, 0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || have_req || start) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (expected_results.size() != 0) err_count++;
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
